@@ rtl/aes_block_cipher_assert.svh @@
// Assertion macros shared by the block cipher RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef AES_BLOCK_CIPHER_ASSERT_SVH
`define AES_BLOCK_CIPHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/aes_pkg.sv @@
// Package for the AES block cipher: payload types, codes, S-box functions.
// No dependencies.
package aes_pkg;

   typedef struct packed {
      logic        op;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   localparam logic [2:0] CSR_KEY_SIZE  = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD2 = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD3 = 3'd4;

   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;
   localparam logic [1:0] KEY_256 = 2'd2;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_INIT,
      ST_ROUND,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_key;   // load first Nk words and reset schedule
      logic       expand;     // compute/write one schedule word
      logic       rk_read;    // issue round key read
      logic [3:0] rk_round;   // round to read
      logic       load_blk;   // capture request block
      logic       init_ark;   // apply initial round key
      logic       do_round;   // apply one round
      logic       last;       // current round is final
      logic       load_rsp;   // capture result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       expand_done;
      logic [3:0] nr;
   } sts_type;

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = t[a];
   endfunction

   function automatic logic [7:0] sbox_inverse(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      sbox_inverse = t[a];
   endfunction

endpackage

@@ rtl/aes_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module aes_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/aes_datapath.sv @@
// Datapath: key registers, key expansion, round-key store and round unit.
// Depends on aes_pkg, aes_ram and aes_block_cipher_assert.svh.
`include "aes_block_cipher_assert.svh"
module aes_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   input  aes_pkg::req_type req_data,
   input  aes_pkg::cmd_type cmd,
   output aes_pkg::sts_type sts,
   output aes_pkg::rsp_type rsp_data
);
   logic [1:0]   key_size_ff;
   logic [255:0] key_ff;
   logic [255:0] win_ff, win_in;      // last Nk schedule words, newest at bottom
   logic [5:0]   widx_ff, widx_in;    // next schedule word index
   logic [2:0]   phase_ff, phase_in;  // i mod Nk
   logic [7:0]   rcon_ff, rcon_in;
   logic [127:0] state_ff, state_in;
   logic         dec_ff;
   aes_pkg::rsp_type rsp_ff;

   logic [3:0]   nk;
   logic [5:0]   total;
   logic         wr_en;
   logic [5:0]   wr_addr;
   logic [31:0]  wr_data;
   logic [127:0] rk;
   logic [31:0]  rk_word [4];
   logic [31:0]  newest, oldest, t, nw;

   always_comb begin
      unique case (key_size_ff)
         aes_pkg::KEY_128: nk = 4'd4;
         aes_pkg::KEY_192: nk = 4'd6;
         default:          nk = 4'd8;
      endcase
   end
   assign total  = 6'({nk, 2'b00} + 6'd28);
   assign sts.nr = nk + 4'd6;
   assign sts.expand_done = (widx_ff == total);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= aes_pkg::KEY_128;
         key_ff      <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            aes_pkg::CSR_KEY_SIZE:
               key_size_ff <= (csr_wdata[1:0] == 2'd3) ? aes_pkg::KEY_256 : csr_wdata[1:0];
            aes_pkg::CSR_KEY_WORD0: key_ff[255:192] <= csr_wdata;
            aes_pkg::CSR_KEY_WORD1: key_ff[191:128] <= csr_wdata;
            aes_pkg::CSR_KEY_WORD2: key_ff[127:64]  <= csr_wdata;
            aes_pkg::CSR_KEY_WORD3: key_ff[63:0]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Key expansion: one word per cycle from a window of the last Nk words.
   always_comb begin
      newest = win_ff[31:0];
      unique case (key_size_ff)
         aes_pkg::KEY_128: oldest = win_ff[127:96];
         aes_pkg::KEY_192: oldest = win_ff[191:160];
         default:          oldest = win_ff[255:224];
      endcase
      t = newest;
      if (phase_ff == 3'd0) begin
         t = {aes_pkg::sbox(newest[23:16]), aes_pkg::sbox(newest[15:8]),
              aes_pkg::sbox(newest[7:0]), aes_pkg::sbox(newest[31:24])}
             ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && phase_ff == 3'd4) begin
         t = {aes_pkg::sbox(newest[31:24]), aes_pkg::sbox(newest[23:16]),
              aes_pkg::sbox(newest[15:8]), aes_pkg::sbox(newest[7:0])};
      end
      nw = oldest ^ t;

      win_in   = win_ff;
      widx_in  = widx_ff;
      phase_in = phase_ff;
      rcon_in  = rcon_ff;
      wr_en    = 1'b0;
      wr_addr  = widx_ff;
      wr_data  = nw;
      if (cmd.load_key) begin
         // Place the key words so the newest sits at the bottom of the window.
         unique case (key_size_ff)
            aes_pkg::KEY_128: win_in = {128'h0, key_ff[255:128]};
            aes_pkg::KEY_192: win_in = {64'h0, key_ff[255:64]};
            default:          win_in = key_ff;
         endcase
         widx_in  = 6'd0;
         phase_in = 3'd0;
         rcon_in  = 8'h01;
      end else if (cmd.expand) begin
         wr_en   = 1'b1;
         widx_in = widx_ff + 6'd1;
         if (widx_ff < 6'(nk)) begin
            // Copy key word i out of the top of the window order.
            unique case (key_size_ff)
               aes_pkg::KEY_128: wr_data = win_ff[127 - 32*widx_ff[1:0] -: 32];
               aes_pkg::KEY_192: wr_data = win_ff[191 - 32*widx_ff[2:0] -: 32];
               default:          wr_data = win_ff[255 - 32*widx_ff[2:0] -: 32];
            endcase
         end else begin
            win_in   = {win_ff[223:0], nw};
            phase_in = (phase_ff == 3'(nk - 4'd1)) ? 3'd0 : phase_ff + 3'd1;
            if (phase_ff == 3'd0) begin
               rcon_in = aes_pkg::xtime(rcon_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      widx_ff  <= widx_in;
      phase_ff <= phase_in;
      rcon_ff  <= rcon_in;
   end

   // Round keys are stored as 4 words each: 15 round keys x 4 = 60 words.
   for (genvar w = 0; w < 4; w++) begin : g_rk
      logic       ram_wr;
      logic [3:0] ram_waddr;
      assign ram_wr    = wr_en && (wr_addr[1:0] == 2'(w));
      assign ram_waddr = wr_addr[5:2];
      aes_ram #(.Width(32), .Depth(16)) u_ram (
         .clock  (clock),
         .wr_en  (ram_wr),
         .wr_addr(ram_waddr),
         .wr_data(wr_data),
         .rd_en  (cmd.rk_read),
         .rd_addr(cmd.rk_round),
         .rd_data(rk_word[w])
      );
   end
   assign rk = {rk_word[0], rk_word[1], rk_word[2], rk_word[3]};

   // Round unit.
   function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
      logic [7:0] a2, a4, a8, r;
      a2 = aes_pkg::xtime(a);
      a4 = aes_pkg::xtime(a2);
      a8 = aes_pkg::xtime(a4);
      r  = (m[0] ? a : 8'h0) ^ (m[1] ? a2 : 8'h0) ^ (m[2] ? a4 : 8'h0) ^ (m[3] ? a8 : 8'h0);
      return r;
   endfunction

   logic [7:0] sb [16];
   logic [7:0] sr [16];
   logic [7:0] mx [16];
   logic [127:0] sub_st, mix_st, pre;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sb[i] = state_ff[127 - 8*i -: 8];
      end
      if (!dec_ff) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               sr[r + 4*c] = aes_pkg::sbox(sb[r + 4*((c + r) % 4)]);
            end
         end
      end else begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               sr[r + 4*c] = aes_pkg::sbox_inverse(sb[r + 4*((c + 4 - r) % 4)]);
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         sub_st[127 - 8*i -: 8] = sr[i];
      end
      // Forward: mix then add key. Inverse: add key then inverse mix.
      pre = dec_ff ? (sub_st ^ rk) : sub_st;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (!dec_ff) begin
               mx[r + 4*c] = gm(pre[127 - 8*(4*c + r) -: 8], 4'd2)
                           ^ gm(pre[127 - 8*(4*c + (r+1)%4) -: 8], 4'd3)
                           ^ gm(pre[127 - 8*(4*c + (r+2)%4) -: 8], 4'd1)
                           ^ gm(pre[127 - 8*(4*c + (r+3)%4) -: 8], 4'd1);
            end else begin
               mx[r + 4*c] = gm(pre[127 - 8*(4*c + r) -: 8], 4'd14)
                           ^ gm(pre[127 - 8*(4*c + (r+1)%4) -: 8], 4'd11)
                           ^ gm(pre[127 - 8*(4*c + (r+2)%4) -: 8], 4'd13)
                           ^ gm(pre[127 - 8*(4*c + (r+3)%4) -: 8], 4'd9);
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         mix_st[127 - 8*i -: 8] = mx[i];
      end

      state_in = state_ff;
      if (cmd.load_blk) begin
         state_in = {req_data.block_high, req_data.block_low};
      end else if (cmd.init_ark) begin
         state_in = state_ff ^ rk;
      end else if (cmd.do_round) begin
         if (cmd.last) begin
            state_in = sub_st ^ rk;
         end else begin
            state_in = dec_ff ? mix_st : (mix_st ^ rk);
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      if (cmd.load_blk) begin
         dec_ff <= (req_data.op == aes_pkg::OP_DECRYPT);
      end
      if (cmd.load_rsp) begin
         rsp_ff <= '{result_high: state_ff[127:64], result_low: state_ff[63:0]};
      end
   end
   assign rsp_data = rsp_ff;

   `AES_ASSERT_IMPL(a_expand_bound, clock, reset, cmd.expand, widx_ff < total)
   `AES_ASSERT_IMPL(a_one_op, clock, reset, cmd.init_ark, !cmd.do_round && !cmd.expand)
   `AES_ASSERT_IMPL(a_key_with_block, clock, reset, cmd.load_key, cmd.load_blk && !cmd.expand)
endmodule

@@ rtl/aes_ctrl.sv @@
// Controller: sequences key expansion, round reads and the handshakes.
// Depends on aes_pkg and aes_block_cipher_assert.svh.
`include "aes_block_cipher_assert.svh"
module aes_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic             req_op,
   input  aes_pkg::sts_type sts,
   output aes_pkg::cmd_type cmd
);
   aes_pkg::state_type state_ff, state_in;
   logic       ready_ff, ready_in;
   logic       dec_ff, dec_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rv_ff, rv_in;
   logic       cfg_hit;

   assign cfg_hit = csr_write && (csr_index <= aes_pkg::CSR_KEY_WORD3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aes_pkg::ST_IDLE;
         ready_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         rv_ff    <= rv_in;
      end
      dec_ff <= dec_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in  = state_ff;
      ready_in  = ready_ff;
      dec_in    = dec_ff;
      cnt_in    = cnt_ff;
      rv_in     = rv_ff && rsp_stall;
      req_stall = 1'b1;
      cmd       = '0;
      if (cfg_hit) begin
         ready_in = 1'b0;
      end
      unique case (state_ff)
         aes_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_blk = 1'b1;
               dec_in       = (req_op == aes_pkg::OP_DECRYPT);
               if (!ready_ff) begin
                  cmd.load_key = 1'b1;
                  state_in     = aes_pkg::ST_EXPAND;
               end else begin
                  cmd.rk_read  = 1'b1;
                  cmd.rk_round = (req_op == aes_pkg::OP_DECRYPT) ? sts.nr : 4'd0;
                  state_in     = aes_pkg::ST_INIT;
               end
            end
         end
         aes_pkg::ST_EXPAND: begin
            if (sts.expand_done) begin
               ready_in     = 1'b1;
               cmd.rk_read  = 1'b1;
               cmd.rk_round = dec_ff ? sts.nr : 4'd0;
               state_in     = aes_pkg::ST_INIT;
            end else begin
               cmd.expand = 1'b1;
            end
         end
         aes_pkg::ST_INIT: begin
            cmd.init_ark = 1'b1;
            cnt_in       = 4'd1;
            cmd.rk_read  = 1'b1;
            cmd.rk_round = dec_ff ? sts.nr - 4'd1 : 4'd1;
            state_in     = aes_pkg::ST_ROUND;
         end
         aes_pkg::ST_ROUND: begin
            cmd.do_round = 1'b1;
            cmd.last     = (cnt_ff == sts.nr);
            cnt_in       = cnt_ff + 4'd1;
            cmd.rk_read  = 1'b1;
            cmd.rk_round = dec_ff ? sts.nr - cnt_in : cnt_in;
            if (cmd.last) begin
               state_in = aes_pkg::ST_DONE;
            end
         end
         aes_pkg::ST_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rv_in        = 1'b1;
               state_in     = aes_pkg::ST_IDLE;
            end
         end
         default: state_in = aes_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;

   `AES_ASSERT_NEXT(a_rsp_load, clock, reset, cmd.load_rsp, rsp_valid)
   `AES_ASSERT_IMPL(a_no_accept_busy, clock, reset,
                    state_ff != aes_pkg::ST_IDLE, req_stall)
   `AES_ASSERT_IMPL(a_round_bound, clock, reset,
                    state_ff == aes_pkg::ST_ROUND, cnt_ff <= sts.nr && cnt_ff != 4'd0)
endmodule

@@ rtl/aes_block_cipher.sv @@
// Top level of the AES-128/192/256 block cipher.
// Depends on aes_pkg, aes_ctrl and aes_datapath.
//
//  channel  | handshake           | beat
//  req      | req_valid/req_stall | aes_pkg::req_type (op, block)
//  rsp      | rsp_valid/rsp_stall | aes_pkg::rsp_type (result)
//  csr      | csr_write           | csr_index, csr_wdata
//
// A block is loaded, gets the initial key add, passes the shared round unit
// at one round per cycle and is then captured as the result.
// The first block after any key or key-size write first expands the schedule,
// one word per cycle into the round-key memories, and then fetches the first
// round key.
// Reset clears the controller; the schedule is then rebuilt on first use.
// A stalled result holds in its output register; the next block is taken
// while it waits.
module aes_block_cipher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aes_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aes_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   aes_pkg::cmd_type cmd;
   aes_pkg::sts_type sts;

   // Sequence the work.
   aes_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .req_op   (req_data.op),
      .sts      (sts),
      .cmd      (cmd)
   );

   // Hold key, schedule and block state.
   aes_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );
endmodule
